/* hdl/upq_pkg.sv */
// Package for the unique priority queue table: opcodes, widths, shared types.
// Used by upq_cell and unique_priority_queue_table; depends on nothing.
`default_nettype none
package upq_pkg;
  localparam int unsigned DefCapacity = 16;
  localparam int unsigned TagW = 16;
  localparam int unsigned PrioW = 16;
  localparam int unsigned CountW = 5;

  typedef enum logic [2:0] {
    OP_ENQ    = 3'd0,
    OP_DEQ    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_GETP   = 3'd3,
    OP_REMOVE = 3'd4,
    OP_CHANGE = 3'd5
  } opcode_t;

  // Command broadcast from the sequencer to every cell.
  typedef enum logic [3:0] {
    CMD_HOLD    = 4'b0001,
    CMD_INSERT  = 4'b0010,
    CMD_COMPACT = 4'b0100,
    CMD_SHIFTUP = 4'b1000
  } cmd_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [TagW-1:0]  tag;
    logic [PrioW-1:0] prio;
  } cell_ctl_t;
endpackage
`default_nettype wire

/* hdl/unique_priority_queue_table.sv */
// Unique priority queue table: a chain of CAPACITY cells sorted by descending priority.
// Each item passes S_EXEC, then S_DONE, where its result is registered; remove range
// and a successful change priority pass S_COMPACT between them; a change re-inserts there.
// Flow: one item at a time; a held result stalls input.
// Synchronous active-low reset empties the chain and the output register.
// Depends on upq_pkg and upq_cell.
`default_nettype none
module unique_priority_queue_table #(
  parameter int unsigned CAPACITY = upq_pkg::DefCapacity
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // in_tdata, low bit first: opcode[2:0], tag[18:3], prio_in[34:19],
  // low_bound[50:35], high_bound[66:51], zero fill[71:67]
  input  wire logic [71:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_tdata, low bit first: ok[0], tag_out[16:1], prio_out[32:17],
  // removed_count[37:33], occupancy[42:38], is_empty[43], zero fill[47:44]
  output logic [47:0]      out_tdata
);
  import upq_pkg::*;
  localparam int unsigned N = CAPACITY;
  localparam int unsigned CW = $clog2(N + 1);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_EXEC    = 4'b0010,
    S_COMPACT = 4'b0100,
    S_DONE    = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] op_r;
  logic [TagW-1:0] tag_r;
  logic [PrioW-1:0] prio_r, lo_r, hi_r;
  logic [CW-1:0] cnt_r, cnt_nxt, rem_r, rem_nxt, steps_r, steps_nxt;
  logic ok_r, ok_nxt, ins_pend_r, ins_pend_nxt;
  logic [TagW-1:0] tago_r, tago_nxt;
  logic [PrioW-1:0] prioo_r, prioo_nxt;
  logic out_vld_r;
  logic [47:0] out_data_r;

  cell_ctl_t ctl;
  logic [N-1:0] vld, ins_here, kill, gap;
  logic [TagW-1:0] ctag [N];
  logic [PrioW-1:0] cprio [N];

  // One cell per slot; slot 0 is the head.
  for (genvar g = 0; g < N; g++) begin : g_cell
    logic up_ins, up_gap, up_vld, dn_vld;
    logic [TagW-1:0] up_tag, dn_tag;
    logic [PrioW-1:0] up_prio, dn_prio;
    if (g == 0) begin : g_top
      assign up_ins = 1'b0; assign up_vld = 1'b0; assign up_gap = 1'b0;
      assign up_tag = '0;   assign up_prio = '0;
    end else begin : g_mid
      assign up_ins = ins_here[g-1]; assign up_vld = vld[g-1];
      assign up_gap = gap[g-1];
      assign up_tag = ctag[g-1];     assign up_prio = cprio[g-1];
    end
    if (g == N - 1) begin : g_bot
      assign dn_vld = 1'b0; assign dn_tag = '0; assign dn_prio = '0;
    end else begin : g_low
      assign dn_vld = vld[g+1] && !kill[g+1];
      assign dn_tag = ctag[g+1]; assign dn_prio = cprio[g+1];
    end
    upq_cell u_cell (
      .clk, .rst_n, .ctl, .kill(kill[g]),
      .up_ins, .up_gap, .up_vld, .up_tag, .up_prio,
      .dn_vld, .dn_tag, .dn_prio,
      .ins_here(ins_here[g]), .gap(gap[g]),
      .vld(vld[g]), .tag(ctag[g]), .prio(cprio[g])
    );
  end

  // Per-slot match flags, all independent compares.
  logic [N-1:0] pmatch, tmatch, inrange;
  always_comb begin
    for (int i = 0; i < N; i++) begin
      pmatch[i]  = vld[i] && (cprio[i] == prio_r);
      tmatch[i]  = vld[i] && (ctag[i] == tag_r);
      inrange[i] = vld[i] && (cprio[i] >= lo_r) && (cprio[i] <= hi_r);
    end
  end

  // Highest-priority tag match is the first in the chain.
  logic [PrioW-1:0] first_prio;
  always_comb begin
    first_prio = '0;
    for (int i = N - 1; i >= 0; i--) if (tmatch[i]) first_prio = cprio[i];
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; rem_nxt = rem_r; steps_nxt = steps_r;
    ok_nxt = ok_r; tago_nxt = tago_r; prioo_nxt = prioo_r;
    ins_pend_nxt = ins_pend_r;
    ctl.cmd = CMD_HOLD; ctl.tag = tag_r; ctl.prio = prio_r;
    kill = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
          ok_nxt = 1'b0; tago_nxt = '0; prioo_nxt = '0; rem_nxt = '0;
          ins_pend_nxt = 1'b0;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (op_r)
          OP_ENQ: begin
            if ((cnt_r < CW'(N)) && !(|pmatch)) begin
              ctl.cmd = CMD_INSERT; ok_nxt = 1'b1; cnt_nxt = cnt_r + 1'b1;
            end
          end
          OP_DEQ, OP_PEEK: begin
            if (vld[0]) begin
              ok_nxt = 1'b1; tago_nxt = ctag[0]; prioo_nxt = cprio[0];
              if (op_r == OP_DEQ) begin
                ctl.cmd = CMD_SHIFTUP; cnt_nxt = cnt_r - 1'b1;
              end
            end
          end
          OP_GETP: begin
            ok_nxt = |tmatch; prioo_nxt = first_prio;
          end
          OP_REMOVE: begin
            ok_nxt = 1'b1;
            ctl.cmd = CMD_COMPACT; kill = inrange;
            rem_nxt = CW'($countones(inrange));
            cnt_nxt = cnt_r - CW'($countones(inrange));
            steps_nxt = CW'(N);
            state_nxt = S_COMPACT;
          end
          OP_CHANGE: begin
            if (!(|pmatch) && ($countones(tmatch) == 1)) begin
              ok_nxt = 1'b1; ctl.cmd = CMD_COMPACT; kill = tmatch;
              ins_pend_nxt = 1'b1; steps_nxt = CW'(N);
              state_nxt = S_COMPACT;
            end
          end
          default: ;
        endcase
      end
      S_COMPACT: begin
        // Each step pulls every slot at or below the first gap up by one, until steps_r runs out.
        if (steps_r != '0) begin
          ctl.cmd = CMD_COMPACT; steps_nxt = steps_r - 1'b1;
        end else if (ins_pend_r) begin
          ctl.cmd = CMD_INSERT; ins_pend_nxt = 1'b0; state_nxt = S_DONE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_vld_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt;
      if (state_r == S_DONE && (!out_vld_r || out_tready)) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
    rem_r <= rem_nxt; steps_r <= steps_nxt; ok_r <= ok_nxt;
    tago_r <= tago_nxt; prioo_r <= prioo_nxt; ins_pend_r <= ins_pend_nxt;
    if (state_r == S_IDLE && in_tvalid) begin
      op_r <= in_tdata[2:0]; tag_r <= in_tdata[18:3]; prio_r <= in_tdata[34:19];
      lo_r <= in_tdata[50:35]; hi_r <= in_tdata[66:51];
    end
    if (state_r == S_DONE && (!out_vld_r || out_tready))
      out_data_r <= {4'b0, (cnt_r == '0), 5'(cnt_r), 5'(rem_r), prioo_r, tago_r, ok_r};
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
endmodule
`default_nettype wire

/* hdl/upq_cell.sv */
// One slot of the sorted chain: holds a valid bit, tag and priority.
// Depends on upq_pkg. Neighbors hand data to it during insert, compaction and shift-up.
`default_nettype none
module upq_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire upq_pkg::cell_ctl_t        ctl,
  input  wire logic                      kill,      // this entry leaves
  input  wire logic                      up_ins,    // upper neighbor takes the new entry or moved
  input  wire logic                      up_gap,    // a gap or leaving entry sits somewhere above
  input  wire logic                      up_vld,
  input  wire logic [upq_pkg::TagW-1:0]  up_tag,
  input  wire logic [upq_pkg::PrioW-1:0] up_prio,
  input  wire logic                      dn_vld,    // lower neighbor data, after its kill
  input  wire logic [upq_pkg::TagW-1:0]  dn_tag,
  input  wire logic [upq_pkg::PrioW-1:0] dn_prio,
  output logic                           ins_here,  // new entry lands here or above
  output logic                           gap,       // this slot or one above is a gap
  output logic                           vld,
  output logic [upq_pkg::TagW-1:0]       tag,
  output logic [upq_pkg::PrioW-1:0]      prio
);
  import upq_pkg::*;
  logic vld_r, vld_nxt;
  logic [TagW-1:0] tag_r, tag_nxt;
  logic [PrioW-1:0] prio_r, prio_nxt;

  // An invalid slot or one with a smaller priority makes way for the new entry.
  assign ins_here = !vld_r || (prio_r < ctl.prio);

  // Every slot at or below the first gap pulls its lower neighbor up by one.
  assign gap = up_gap || kill || !vld_r;

  always_comb begin
    vld_nxt  = vld_r;
    tag_nxt  = tag_r;
    prio_nxt = prio_r;
    case (ctl.cmd)
      CMD_INSERT: begin
        if (up_ins) begin
          vld_nxt = up_vld; tag_nxt = up_tag; prio_nxt = up_prio;
        end else if (ins_here) begin
          vld_nxt = 1'b1; tag_nxt = ctl.tag; prio_nxt = ctl.prio;
        end
      end
      CMD_COMPACT: begin
        if (gap) begin
          vld_nxt = dn_vld; tag_nxt = dn_tag; prio_nxt = dn_prio;
        end
      end
      CMD_SHIFTUP: begin
        vld_nxt = dn_vld; tag_nxt = dn_tag; prio_nxt = dn_prio;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_nxt;
    tag_r  <= tag_nxt;
    prio_r <= prio_nxt;
  end

  assign vld  = vld_r;
  assign tag  = tag_r;
  assign prio = prio_r;
endmodule
`default_nettype wire
